>>> src/lifo_stack_with_search_assert.svh
// Assertion macros for the LIFO stack with search.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LIFO_STACK_WITH_SEARCH_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define LSWS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define LSWS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lsws_pkg.sv
// Shared types, constants and word helpers for the LIFO stack with search.
// No dependencies.
package lsws_pkg;

  localparam int DEPTH     = 256;
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_e_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    mode_e_t            mode;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    status_e_t          status;
    logic signed [31:0] result_value;
    logic [7:0]         match_position;
    logic [8:0]         entry_count;
  } out_t;

  // Control broadcast from the sequencer to the cell row.
  typedef struct packed {
    cell_op_t op;
    word_t    push_word;
  } cell_ctl_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] cnt;
  } ctl_stat_t;

  // 32-bit field -> stored word: sign-extend, then cut to WORD_BITS.
  function automatic word_t word_in(input logic [31:0] v);
    return word_t'($signed(v));
  endfunction

  // Stored word -> 32-bit field: sign-extend from WORD_BITS, then cut.
  function automatic logic [31:0] word_out(input word_t w);
    return 32'($signed(w));
  endfunction

endpackage

>>> src/lsws_cell.sv
// One stack cell: holds a word, shifts with its neighbors.
// Depends on lsws_pkg.
module lsws_cell import lsws_pkg::*; (
  input  logic     clk,
  input  cell_op_t op,
  input  word_t    above_word,  // neighbor toward the top (push source)
  input  word_t    below_word,  // neighbor toward the bottom (pop source)
  input  word_t    wrap_word,   // top cell, for rotation
  input  logic     wrap_sel,    // this cell is the lowest held entry
  output word_t    word
);

  word_t word_r;
  word_t word_nxt;

  always_comb begin
    case (op)
      CELL_PUSH: word_nxt = above_word;
      CELL_POP:  word_nxt = below_word;
      CELL_ROT:  word_nxt = wrap_sel ? wrap_word : below_word;
      default:   word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

>>> src/lsws_ctl.sv
// Sequencer: handshakes, entry count, search walk and result register.
// Depends on lsws_pkg.
module lsws_ctl import lsws_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_t       in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_t      out_data,
  input  word_t     top_word,
  output cell_ctl_t cell_ctl,
  output ctl_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SRCH = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  word_t            key_r, key_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;
  logic             accept;
  logic             hit;
  word_t            in_word;

  function automatic out_t mk_out(input status_e_t st, input logic [31:0] rv,
                                  input logic [IDX_W-1:0] pos,
                                  input logic [CNT_W-1:0] cnt);
    out_t o;
    o.status         = st;
    o.result_value   = rv;
    o.match_position = 8'(pos);
    o.entry_count    = 9'(cnt);
    return o;
  endfunction

  assign in_stall = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign accept   = in_valid && !in_stall;
  assign hit      = (top_word == key_r);
  assign in_word  = word_in(in_data.value);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    key_nxt        = key_r;
    step_nxt       = step_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    cell_ctl.op    = CELL_HOLD;
    cell_ctl.push_word = in_word;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          unique case (in_data.mode)
            MODE_PUSH: begin
              if (cnt_r == CNT_W'(DEPTH)) begin
                out_nxt = mk_out(STAT_FULL, 32'd0, '0, cnt_r);
              end else begin
                cell_ctl.op = CELL_PUSH;
                cnt_nxt     = cnt_r + 1'b1;
                out_nxt     = mk_out(STAT_OK, 32'd0, '0, cnt_r + 1'b1);
              end
            end
            MODE_POP: begin
              if (cnt_r == '0) begin
                out_nxt = mk_out(STAT_EMPTY, 32'd0, '0, cnt_r);
              end else begin
                cell_ctl.op = CELL_POP;
                cnt_nxt     = cnt_r - 1'b1;
                out_nxt     = mk_out(STAT_OK, word_out(top_word), '0, cnt_r - 1'b1);
              end
            end
            MODE_PEEK: begin
              if (cnt_r == '0) begin
                out_nxt = mk_out(STAT_EMPTY, 32'd0, '0, cnt_r);
              end else begin
                out_nxt = mk_out(STAT_OK, word_out(top_word), '0, cnt_r);
              end
            end
            MODE_SEARCH: begin
              if (cnt_r == '0) begin
                out_nxt = mk_out(STAT_NOT_FOUND, 32'd0, '0, cnt_r);
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_SRCH;
                key_nxt       = in_word;
                step_nxt      = '0;
                pos_nxt       = '0;
                found_nxt     = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        // Rotate one entry through the top per cycle; first hit is nearest top.
        cell_ctl.op = CELL_ROT;
        step_nxt    = step_r + 1'b1;
        if (hit && !found_r) begin
          found_nxt = 1'b1;
          pos_nxt   = step_r;
        end
        if (CNT_W'(step_r) == cnt_r - 1'b1) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (found_r || hit) begin
            out_nxt = mk_out(STAT_OK, word_out(key_r), found_r ? pos_r : step_r, cnt_r);
          end else begin
            out_nxt = mk_out(STAT_NOT_FOUND, 32'd0, '0, cnt_r);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pos_r <= pos_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign stat.busy = (state_r == S_SRCH);
  assign stat.cnt  = cnt_r;

endmodule

>>> src/lifo_stack_with_search.sv
// LIFO stack with search: push, pop and peek return their result in the cycle after
// the transaction is accepted, and a new transaction can follow every cycle while the
// output is not stalled. A search over N held entries accepts the transaction, then
// rotates one entry through the top cell per cycle and accepts nothing meanwhile; on an
// empty stack it returns not found without walking the row.
// Reset (rst_n low, synchronous) empties the stack and drops any pending result;
// cell contents are not cleared.
// Depends on lsws_pkg, lsws_cell, lsws_ctl and the assertion macro header.
`include "lifo_stack_with_search_assert.svh"

module lifo_stack_with_search import lsws_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // Cell 0 is the top of the stack; cell i is i entries below the top.
  word_t     cell_word [DEPTH];
  cell_ctl_t cell_ctl;
  ctl_stat_t stat;
  logic      in_accept;

  assign in_accept = in_valid && !in_stall;

  // Sequencer owns the count, the search walk and the output register.
  lsws_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .top_word  (cell_word[0]),
    .cell_ctl  (cell_ctl),
    .stat      (stat)
  );

  // Row of cells. Push shifts down (new word into cell 0), pop shifts up.
  // Rotate shifts up and wraps cell 0 into the lowest held entry, so after
  // N rotations over N entries the stack is back in its original order.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t above_w;
    word_t below_w;
    logic  wrap_sel;

    if (i == 0) begin : g_top
      assign above_w = cell_ctl.push_word;
    end else begin : g_mid
      assign above_w = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      assign below_w = cell_word[i];
    end else begin : g_up
      assign below_w = cell_word[i+1];
    end

    assign wrap_sel = (CNT_W'(i) == stat.cnt - 1'b1);

    lsws_cell u_cell (
      .clk        (clk),
      .op         (cell_ctl.op),
      .above_word (above_w),
      .below_word (below_w),
      .wrap_word  (cell_word[0]),
      .wrap_sel   (wrap_sel),
      .word       (cell_word[i])
    );
  end

  // Count never passes the capacity.
  `LSWS_ASSERT(a_cnt_max, 1'b1, stat.cnt <= CNT_W'(DEPTH), "entry count above depth")
  // No transaction is taken while a search walks the row.
  `LSWS_ASSERT(a_busy_stall, stat.busy, in_stall, "input accepted during search")
  // A push into a non-full stack grows it by exactly one.
  `LSWS_ASSERT_NXT(a_push_cnt,
    in_accept && (in_data.mode == MODE_PUSH) && (stat.cnt != CNT_W'(DEPTH)),
    stat.cnt == $past(stat.cnt) + 1'b1, "push did not bump count")
  // A pop from a non-empty stack shrinks it by exactly one.
  `LSWS_ASSERT_NXT(a_pop_cnt,
    in_accept && (in_data.mode == MODE_POP) && (stat.cnt != '0),
    stat.cnt == $past(stat.cnt) - 1'b1, "pop did not drop count")

endmodule
